[design/tlb_pkg.sv]
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types and codes for the TLB translate and maintenance block.
// ----------------------------------------------------------------------------
package tlb_pkg;

    typedef enum logic [2:0] {
        ACT_TRANSLATE  = 3'd0,
        ACT_READ       = 3'd1,
        ACT_WRITE      = 3'd2,
        ACT_SEARCH     = 3'd3,
        ACT_INVALIDATE = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        FLT_NONE     = 3'd0,
        FLT_REFILL   = 3'd1,
        FLT_FETCH    = 3'd2,
        FLT_LOAD     = 3'd3,
        FLT_STORE    = 3'd4,
        FLT_PRIV     = 3'd5,
        FLT_MODIFY   = 3'd6
    } t_fault;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_STORE = 2'd2;

    localparam logic [2:0] INV_ALL      = 3'd0;
    localparam logic [2:0] INV_ALL1     = 3'd1;
    localparam logic [2:0] INV_GLOBAL   = 3'd2;
    localparam logic [2:0] INV_LOCAL    = 3'd3;
    localparam logic [2:0] INV_ASID     = 3'd4;
    localparam logic [2:0] INV_ASID_VA  = 3'd5;
    localparam logic [2:0] INV_MATCH_VA = 3'd6;
    localparam logic [2:0] INV_BAD      = 3'd7;

    localparam logic [1:0] CFG_DIRECT = 2'd0;
    localparam logic [1:0] CFG_WIN0   = 2'd1;
    localparam logic [1:0] CFG_WIN1   = 2'd2;

    localparam logic [5:0] PS_MIN = 6'd12;
    localparam logic [5:0] PS_MAX = 6'd30;

    typedef struct packed {
        logic [18:0] vppn;
        logic [5:0]  ps;
        logic        g;
        logic [9:0]  asid;
        logic        present;
    } t_tag;

    typedef struct packed {
        logic [19:0] ppn;
        logic [1:0]  plv;
        logic [1:0]  mat;
        logic        d;
        logic        v;
    } t_page;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] vaddr;
        logic [1:0]  kind;
        logic [1:0]  plv;
        logic [9:0]  asid;
        logic [3:0]  index;
        logic [5:0]  ps;
        logic [31:0] lo0;
        logic [31:0] lo1;
        logic        not_exist;
        logic        refill;
        logic [2:0]  op;
    } t_req;

    typedef struct packed {
        logic [31:0] paddr;
        logic [2:0]  fault;
        logic        found;
        logic [3:0]  found_index;
        logic [31:0] entry_hi;
        logic [31:0] read_lo0;
        logic [31:0] read_lo1;
        logic [5:0]  entry_ps;
        logic [9:0]  entry_asid;
        logic        op_ok;
    } t_rsp;

    function automatic t_page unpack_lo(input logic [31:0] w);
        t_page p;
        p.ppn = w[27:8];
        p.plv = w[3:2];
        p.mat = w[5:4];
        p.d   = w[1];
        p.v   = w[0];
        return p;
    endfunction

    function automatic logic [31:0] pack_lo(input t_page p, input logic g);
        return {4'd0, p.ppn, 1'b0, g, p.mat, p.plv, p.d, p.v};
    endfunction

endpackage

[design/tlb_store.sv]
// ----------------------------------------------------------------------------
// tlb_store
// Entry storage: tag and page pair registers, write and selective clear.
// ----------------------------------------------------------------------------
module tlb_store import tlb_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_update,
    input  t_req                i_req,
    output t_tag  [ENTRIES-1:0] o_tag,
    output t_page [ENTRIES-1:0] o_even,
    output t_page [ENTRIES-1:0] o_odd
);

    t_tag  [ENTRIES-1:0] r_tag;
    t_page [ENTRIES-1:0] r_even;
    t_page [ENTRIES-1:0] r_odd;
    logic  [ENTRIES-1:0] n_clr;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            unique case (i_req.op)
                INV_GLOBAL:   n_clr[i] = r_tag[i].g;
                INV_LOCAL:    n_clr[i] = !r_tag[i].g;
                INV_ASID:     n_clr[i] = !r_tag[i].g && r_tag[i].asid == i_req.asid;
                INV_ASID_VA:  n_clr[i] = !r_tag[i].g && r_tag[i].asid == i_req.asid
                                         && r_tag[i].vppn == i_req.vaddr[31:13];
                INV_MATCH_VA: n_clr[i] = (r_tag[i].g || r_tag[i].asid == i_req.asid)
                                         && r_tag[i].vppn == i_req.vaddr[31:13];
                INV_BAD:      n_clr[i] = 1'b0;
                default:      n_clr[i] = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_even <= '0;
            r_odd  <= '0;
        end else if (i_update) begin
            if (i_req.action == ACT_WRITE) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (32'(i_req.index) == 32'(i)) begin
                        r_tag[i].vppn    <= i_req.vaddr[31:13];
                        r_tag[i].ps      <= i_req.ps;
                        r_tag[i].g       <= i_req.lo0[6] & i_req.lo1[6];
                        r_tag[i].asid    <= i_req.asid;
                        r_tag[i].present <= i_req.refill | ~i_req.not_exist;
                        r_even[i]        <= unpack_lo(i_req.lo0);
                        r_odd[i]         <= unpack_lo(i_req.lo1);
                    end
                end
            end else if (i_req.action == ACT_INVALIDATE) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (n_clr[i]) begin
                        r_tag[i].present <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_tag  = r_tag;
    assign o_even = r_even;
    assign o_odd  = r_odd;

endmodule

[design/tlb_lookup.sv]
// ----------------------------------------------------------------------------
// tlb_lookup
// Combinational translate, read and search on the registered request.
// ----------------------------------------------------------------------------
module tlb_lookup import tlb_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  t_req                i_req,
    input  logic                i_direct,
    input  logic [31:0]         i_win0,
    input  logic [31:0]         i_win1,
    input  t_tag  [ENTRIES-1:0] i_tag,
    input  t_page [ENTRIES-1:0] i_even,
    input  t_page [ENTRIES-1:0] i_odd,
    output t_rsp                o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] w_thit;
    logic [ENTRIES-1:0] w_shit;
    logic [IW-1:0]      w_tidx;
    logic [IW-1:0]      w_sidx;
    logic               w_tany;
    logic               w_sany;
    logic               w_w0;
    logic               w_w1;
    t_tag               w_t;
    t_page              w_p;
    logic [31:0]        w_mask;
    logic [31:0]        w_ppa;
    logic               w_rdok;
    logic [IW-1:0]      w_ridx;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            logic [31:0] sh;
            sh = 32'(i_tag[i].ps) - 32'd12;
            w_thit[i] = i_tag[i].present
                && (i_tag[i].g || i_tag[i].asid == i_req.asid)
                && i_tag[i].ps >= PS_MIN && i_tag[i].ps <= PS_MAX
                && ((32'(i_tag[i].vppn) >> sh[4:0]) == (i_req.vaddr >> sh[4:0] >> 13));
            w_shit[i] = i_tag[i].present
                && (i_tag[i].g || i_tag[i].asid == i_req.asid)
                && i_tag[i].vppn == i_req.vaddr[31:13];
        end
        w_tidx = '0;
        w_sidx = '0;
        w_tany = 1'b0;
        w_sany = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_thit[i]) begin
                w_tidx = IW'(i);
                w_tany = 1'b1;
            end
            if (w_shit[i]) begin
                w_sidx = IW'(i);
                w_sany = 1'b1;
            end
        end
    end

    assign w_w0 = i_win0[31:29] == i_req.vaddr[31:29] && i_win0[i_req.plv];
    assign w_w1 = i_win1[31:29] == i_req.vaddr[31:29] && i_win1[i_req.plv];
    assign w_t  = i_tag[w_tidx];
    assign w_p  = i_req.vaddr[w_t.ps[4:0]] ? i_odd[w_tidx] : i_even[w_tidx];
    assign w_mask = (32'd1 << w_t.ps[4:0]) - 32'd1;
    assign w_ppa  = (({12'd0, w_p.ppn} << 12) & ~w_mask) | (i_req.vaddr & w_mask);
    assign w_rdok = 32'(i_req.index) < 32'(ENTRIES);
    assign w_ridx = IW'(i_req.index);

    always_comb begin
        o_rsp = '0;
        o_rsp.op_ok = 1'b1;
        unique case (i_req.action)
            ACT_TRANSLATE: begin
                o_rsp.paddr = i_req.vaddr;
                if (i_direct) begin
                    o_rsp.paddr = i_req.vaddr;
                end else if (w_w0) begin
                    o_rsp.paddr = {i_win0[27:25], i_req.vaddr[28:0]};
                end else if (w_w1) begin
                    o_rsp.paddr = {i_win1[27:25], i_req.vaddr[28:0]};
                end else if (!w_tany) begin
                    o_rsp.fault = FLT_REFILL;
                end else if (!w_p.v) begin
                    if (i_req.kind == KIND_FETCH) o_rsp.fault = FLT_FETCH;
                    else if (i_req.kind == KIND_LOAD) o_rsp.fault = FLT_LOAD;
                    else if (i_req.kind == KIND_STORE) o_rsp.fault = FLT_STORE;
                end else if (i_req.plv > w_p.plv) begin
                    o_rsp.fault = FLT_PRIV;
                end else if (i_req.kind == KIND_STORE && !w_p.d) begin
                    o_rsp.fault = FLT_MODIFY;
                end else begin
                    o_rsp.paddr = w_ppa;
                end
            end
            ACT_READ: begin
                if (w_rdok && i_tag[w_ridx].present) begin
                    o_rsp.found      = 1'b1;
                    o_rsp.entry_hi   = {i_tag[w_ridx].vppn, 13'd0};
                    o_rsp.read_lo0   = pack_lo(i_even[w_ridx], i_tag[w_ridx].g);
                    o_rsp.read_lo1   = pack_lo(i_odd[w_ridx], i_tag[w_ridx].g);
                    o_rsp.entry_ps   = i_tag[w_ridx].ps;
                    o_rsp.entry_asid = i_tag[w_ridx].asid;
                end
            end
            ACT_SEARCH: begin
                o_rsp.found       = w_sany;
                o_rsp.found_index = 4'(w_sidx);
            end
            ACT_INVALIDATE: begin
                o_rsp.op_ok = i_req.op != INV_BAD;
            end
            default: begin
                o_rsp.op_ok = 1'b1;
            end
        endcase
    end

endmodule

[design/tlb_translate_and_maintain.sv]
// ----------------------------------------------------------------------------
// tlb_translate_and_maintain
// Fully associative TLB with two direct-map windows and maintenance actions.
// Each accepted transaction passes the request register, then the result register.
// Throughput: one transaction per cycle while the result side does not stall; all entries are matched in parallel.
// Reset (synchronous, active low): all entries not present, direct mode on.
// Writes and invalidates update the entry store as the result is formed.
// ----------------------------------------------------------------------------
module tlb_translate_and_maintain import tlb_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_vaddr,
    input  logic [1:0]  i_access_kind,
    input  logic [1:0]  i_privilege,
    input  logic [9:0]  i_asid,
    input  logic [3:0]  i_index,
    input  logic [5:0]  i_page_size,
    input  logic [31:0] i_entry_lo0,
    input  logic [31:0] i_entry_lo1,
    input  logic        i_not_exist,
    input  logic        i_refill_mode,
    input  logic [2:0]  i_invalidate_op,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_paddr,
    output logic [2:0]  o_fault,
    output logic        o_found,
    output logic [3:0]  o_found_index,
    output logic [31:0] o_entry_hi,
    output logic [31:0] o_read_lo0,
    output logic [31:0] o_read_lo1,
    output logic [5:0]  o_entry_ps,
    output logic [9:0]  o_entry_asid,
    output logic        o_op_ok
);

    // config registers
    logic        r_direct;
    logic [31:0] r_win0;
    logic [31:0] r_win1;

    // stage 1: request register; stage 2: result register
    logic        r_req_vld;
    t_req        r_req;
    logic        r_rsp_vld;
    t_rsp        r_rsp;
    t_rsp        w_rsp;
    logic        w_adv;   // stage 1 moves into result register

    t_tag  [ENTRIES-1:0] w_tag;
    t_page [ENTRIES-1:0] w_even;
    t_page [ENTRIES-1:0] w_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct <= 1'b1;
            r_win0   <= '0;
            r_win1   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIRECT: r_direct <= i_cfg_data[0];
                CFG_WIN0:   r_win0   <= i_cfg_data;
                CFG_WIN1:   r_win1   <= i_cfg_data;
                default:    r_direct <= r_direct;
            endcase
        end
    end

    // result register frees when empty or being taken
    assign w_adv   = r_req_vld && (!r_rsp_vld || !i_stall);
    assign o_stall = r_req_vld && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (i_valid && !o_stall) r_req_vld <= 1'b1;
            else if (w_adv)          r_req_vld <= 1'b0;
            if (w_adv)               r_rsp_vld <= 1'b1;
            else if (!i_stall)       r_rsp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= '{action: i_action, vaddr: i_vaddr, kind: i_access_kind,
                       plv: i_privilege, asid: i_asid, index: i_index,
                       ps: i_page_size, lo0: i_entry_lo0, lo1: i_entry_lo1,
                       not_exist: i_not_exist, refill: i_refill_mode,
                       op: i_invalidate_op};
        end
        if (w_adv) r_rsp <= w_rsp;
    end

    // store updates commit once, when the transaction leaves stage 1
    tlb_store #(.ENTRIES(ENTRIES)) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_adv),
        .i_req    (r_req),
        .o_tag    (w_tag),
        .o_even   (w_even),
        .o_odd    (w_odd)
    );

    tlb_lookup #(.ENTRIES(ENTRIES)) u_lookup (
        .i_req    (r_req),
        .i_direct (r_direct),
        .i_win0   (r_win0),
        .i_win1   (r_win1),
        .i_tag    (w_tag),
        .i_even   (w_even),
        .i_odd    (w_odd),
        .o_rsp    (w_rsp)
    );

    assign o_valid       = r_rsp_vld;
    assign o_paddr       = r_rsp.paddr;
    assign o_fault       = r_rsp.fault;
    assign o_found       = r_rsp.found;
    assign o_found_index = r_rsp.found_index;
    assign o_entry_hi    = r_rsp.entry_hi;
    assign o_read_lo0    = r_rsp.read_lo0;
    assign o_read_lo1    = r_rsp.read_lo1;
    assign o_entry_ps    = r_rsp.entry_ps;
    assign o_entry_asid  = r_rsp.entry_asid;
    assign o_op_ok       = r_rsp.op_ok;

endmodule

[design/tlb_checker.sv]
// ----------------------------------------------------------------------------
// tlb_checker
// Port-level checks for the TLB block, bound to the top level.
// ----------------------------------------------------------------------------
module tlb_checker import tlb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_fault,
    input logic        o_found,
    input logic [31:0] o_paddr,
    input logic        o_op_ok
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_paddr))
        else $error("result dropped under stall");

    a_fault_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fault <= FLT_MODIFY)
        else $error("bad fault code");

    a_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault != FLT_NONE |-> !o_found && o_op_ok)
        else $error("fault with other status");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind tlb_translate_and_maintain tlb_checker u_tlb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_fault (o_fault),
    .o_found (o_found),
    .o_paddr (o_paddr),
    .o_op_ok (o_op_ok)
);

[dv/tlb_translate_and_maintain_tb.sv]
// ----------------------------------------------------------------------------
// tlb_translate_and_maintain_tb
// Self-checking bench for the TLB: a directed table of transactions, then
// random traffic built around written entries, with window and mode settings
// changed between phases. A scoreboard model predicts each result.
// ----------------------------------------------------------------------------
module tlb_translate_and_maintain_tb;
    import tlb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENT     = 16;
    localparam int CYC_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [31:0] i_vaddr;
    logic [1:0]  i_access_kind;
    logic [1:0]  i_privilege;
    logic [9:0]  i_asid;
    logic [3:0]  i_index;
    logic [5:0]  i_page_size;
    logic [31:0] i_entry_lo0;
    logic [31:0] i_entry_lo1;
    logic        i_not_exist;
    logic        i_refill_mode;
    logic [2:0]  i_invalidate_op;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_paddr;
    logic [2:0]  o_fault;
    logic        o_found;
    logic [3:0]  o_found_index;
    logic [31:0] o_entry_hi;
    logic [31:0] o_read_lo0;
    logic [31:0] o_read_lo1;
    logic [5:0]  o_entry_ps;
    logic [9:0]  o_entry_asid;
    logic        o_op_ok;

    tlb_translate_and_maintain #(.ENTRIES(N_ENT)) dut (.*);

    // Scoreboard copy of the TLB state and registers
    t_tag        mdl_tag  [N_ENT];
    t_page       mdl_even [N_ENT];
    t_page       mdl_odd  [N_ENT];
    logic        mdl_direct;
    logic [31:0] mdl_win0;
    logic [31:0] mdl_win1;

    t_rsp        rsp_q[$];
    int          err_cnt;
    longint      cyc;
    bit          quiet;     // no idling in the final stretch
    int          vpn_pool[$];
    bit          have_exp;
    t_rsp        exp_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("FAIL tlb_translate_and_maintain");
            $finish;
        end
    end

    function automatic bit win_hit(input logic [31:0] win, input logic [31:0] va,
                                   input logic [1:0] plv, output logic [31:0] pa);
        pa = {win[27:25], va[28:0]};
        return (win[31:29] == va[31:29]) && win[plv];
    endfunction

    function automatic t_rsp tlb_predict(input t_req r);
        t_rsp  o;
        logic [31:0] pa;
        int    hit;
        int    ps;
        t_page p;
        logic [31:0] msk;
        bit    clr;
        o = '0;
        o.op_ok = 1'b1;
        case (r.action)
            ACT_TRANSLATE: begin
                o.paddr = r.vaddr;
                hit = -1;
                if (mdl_direct) return o;
                if (win_hit(mdl_win0, r.vaddr, r.plv, pa)) begin o.paddr = pa; return o; end
                if (win_hit(mdl_win1, r.vaddr, r.plv, pa)) begin o.paddr = pa; return o; end
                for (int i = 0; i < N_ENT; i++) begin
                    if (hit < 0 && mdl_tag[i].present &&
                        (mdl_tag[i].g || mdl_tag[i].asid == r.asid) &&
                        mdl_tag[i].ps >= PS_MIN && mdl_tag[i].ps <= PS_MAX &&
                        (32'(mdl_tag[i].vppn) >> (mdl_tag[i].ps - 12)) ==
                        (r.vaddr >> (mdl_tag[i].ps + 1)))
                        hit = i;
                end
                if (hit < 0) begin o.fault = FLT_REFILL; return o; end
                ps = mdl_tag[hit].ps;
                p = r.vaddr[ps] ? mdl_odd[hit] : mdl_even[hit];
                if (!p.v) begin
                    case (r.kind)
                        KIND_FETCH: o.fault = FLT_FETCH;
                        KIND_LOAD:  o.fault = FLT_LOAD;
                        KIND_STORE: o.fault = FLT_STORE;
                        default:    o.fault = FLT_NONE;
                    endcase
                    return o;
                end
                if (r.plv > p.plv) begin o.fault = FLT_PRIV; return o; end
                if (r.kind == KIND_STORE && !p.d) begin o.fault = FLT_MODIFY; return o; end
                msk = (32'd1 << ps) - 1;
                o.paddr = (((32'(p.ppn) >> (ps - 12)) << ps) | (r.vaddr & msk));
            end
            ACT_READ: begin
                if (mdl_tag[r.index].present) begin
                    o.found      = 1'b1;
                    o.entry_hi   = {mdl_tag[r.index].vppn, 13'd0};
                    o.read_lo0   = {4'd0, mdl_even[r.index].ppn, 1'b0, mdl_tag[r.index].g,
                                    mdl_even[r.index].mat, mdl_even[r.index].plv,
                                    mdl_even[r.index].d, mdl_even[r.index].v};
                    o.read_lo1   = {4'd0, mdl_odd[r.index].ppn, 1'b0, mdl_tag[r.index].g,
                                    mdl_odd[r.index].mat, mdl_odd[r.index].plv,
                                    mdl_odd[r.index].d, mdl_odd[r.index].v};
                    o.entry_ps   = mdl_tag[r.index].ps;
                    o.entry_asid = mdl_tag[r.index].asid;
                end
            end
            ACT_WRITE: begin
                mdl_tag[r.index].vppn    = r.vaddr[31:13];
                mdl_tag[r.index].ps      = r.ps;
                mdl_tag[r.index].g       = r.lo0[6] & r.lo1[6];
                mdl_tag[r.index].asid    = r.asid;
                mdl_tag[r.index].present = r.refill | ~r.not_exist;
                mdl_even[r.index] = '{r.lo0[27:8], r.lo0[3:2], r.lo0[5:4], r.lo0[1], r.lo0[0]};
                mdl_odd[r.index]  = '{r.lo1[27:8], r.lo1[3:2], r.lo1[5:4], r.lo1[1], r.lo1[0]};
            end
            ACT_SEARCH: begin
                for (int i = N_ENT - 1; i >= 0; i--)
                    if (mdl_tag[i].present && (mdl_tag[i].g || mdl_tag[i].asid == r.asid) &&
                        mdl_tag[i].vppn == r.vaddr[31:13]) begin
                        o.found = 1'b1;
                        o.found_index = 4'(i);
                    end
            end
            ACT_INVALIDATE: begin
                if (r.op == INV_BAD) o.op_ok = 1'b0;
                else for (int i = 0; i < N_ENT; i++) begin
                    case (r.op)
                        INV_GLOBAL:  clr = mdl_tag[i].g;
                        INV_LOCAL:   clr = !mdl_tag[i].g;
                        INV_ASID:    clr = !mdl_tag[i].g && mdl_tag[i].asid == r.asid;
                        INV_ASID_VA: clr = !mdl_tag[i].g && mdl_tag[i].asid == r.asid &&
                                           mdl_tag[i].vppn == r.vaddr[31:13];
                        INV_MATCH_VA: clr = (mdl_tag[i].g || mdl_tag[i].asid == r.asid) &&
                                            mdl_tag[i].vppn == r.vaddr[31:13];
                        default:     clr = 1'b1;
                    endcase
                    if (clr) mdl_tag[i].present = 1'b0;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // Result side: random stall bursts, compare each transaction in order
    initial begin
        t_rsp e;
        int   n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (rsp_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = rsp_q.pop_front();
                    if (o_paddr != e.paddr) report_mismatch("paddr", o_paddr, e.paddr);
                    if (o_fault != e.fault) report_mismatch("fault", o_fault, e.fault);
                    if (o_found != e.found) report_mismatch("found", o_found, e.found);
                    if (o_found_index != e.found_index)
                        report_mismatch("found_index", o_found_index, e.found_index);
                    if (o_entry_hi != e.entry_hi)
                        report_mismatch("entry_hi", o_entry_hi, e.entry_hi);
                    if (o_read_lo0 != e.read_lo0)
                        report_mismatch("read_lo0", o_read_lo0, e.read_lo0);
                    if (o_read_lo1 != e.read_lo1)
                        report_mismatch("read_lo1", o_read_lo1, e.read_lo1);
                    if (o_entry_ps != e.entry_ps)
                        report_mismatch("entry_ps", o_entry_ps, e.entry_ps);
                    if (o_entry_asid != e.entry_asid)
                        report_mismatch("entry_asid", o_entry_asid, e.entry_asid);
                    if (o_op_ok != e.op_ok) report_mismatch("op_ok", o_op_ok, e.op_ok);
                end
            end
            if (n > 0) begin
                n--;
                if (n == 0) i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                i_stall <= 1'b1;
            end
        end
    end

    // Drive one transaction; queue its prediction when it is accepted
    task automatic send_txn(input t_req r, input bit chk_row, input t_rsp row);
        t_rsp p;
        int   gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_action        <= r.action;
        i_vaddr         <= r.vaddr;
        i_access_kind   <= r.kind;
        i_privilege     <= r.plv;
        i_asid          <= r.asid;
        i_index         <= r.index;
        i_page_size     <= r.ps;
        i_entry_lo0     <= r.lo0;
        i_entry_lo1     <= r.lo1;
        i_not_exist     <= r.not_exist;
        i_refill_mode   <= r.refill;
        i_invalidate_op <= r.op;
        do @(posedge i_clk); while (o_stall);
        p = tlb_predict(r);
        if (chk_row && p != row) report_mismatch("table row vs scoreboard", 0, 0);
        rsp_q.push_back(chk_row ? row : p);
    endtask

    task automatic drain_and_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_DIRECT: mdl_direct = val[0];
            CFG_WIN0:   mdl_win0   = val;
            default:    mdl_win1   = val;
        endcase
    endtask

    function automatic t_req blank_req(input t_action a);
        t_req r;
        r = '0;
        r.action = a;
        return r;
    endfunction

    // Random transaction, mostly aimed at pages already written
    function automatic t_req rand_req();
        t_req r;
        int   k;
        r.action    = 3'($urandom_range(0, 9) < 5 ? ACT_TRANSLATE : $urandom_range(0, 7));
        r.vaddr     = $urandom;
        r.kind      = 2'($urandom);
        r.plv       = 2'($urandom);
        r.asid      = 10'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
        r.index     = 4'($urandom);
        r.ps        = 6'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(12, 30));
        if ($urandom_range(0, 3) == 0) r.ps = 6'(12 + 2 * $urandom_range(0, 1));
        r.lo0       = $urandom;
        r.lo1       = $urandom;
        r.not_exist = ($urandom_range(0, 4) == 0);
        r.refill    = ($urandom_range(0, 4) == 0);
        r.op        = 3'($urandom);
        if (r.action == ACT_INVALIDATE && $urandom_range(0, 2) != 0) r.op = INV_ASID_VA;
        if (vpn_pool.size() != 0 && r.action != ACT_WRITE && $urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, vpn_pool.size() - 1);
            r.vaddr = (vpn_pool[k] & 32'hffff_e000) | ($urandom & 32'h1fff);
            if ($urandom_range(0, 1) == 0) r.vaddr[25:13] = 13'($urandom);
        end
        if (r.action == ACT_WRITE) begin
            vpn_pool.push_back(r.vaddr);
            if (vpn_pool.size() > 12) void'(vpn_pool.pop_front());
        end
        return r;
    endfunction

    // Directed table: request plus, where obvious, the expected result
    typedef struct {
        t_req r;
        bit   chk;
        t_rsp e;
    } t_row;

    initial begin
        t_row tbl[$];
        t_row w;
        t_req r;
        t_rsp ok_rsp;
        logic [31:0] win_cfg[4];

        cyc = 0; err_cnt = 0; quiet = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_action = '0; i_vaddr = '0; i_access_kind = '0;
        i_privilege = '0; i_asid = '0; i_index = '0; i_page_size = '0;
        i_entry_lo0 = '0; i_entry_lo1 = '0; i_not_exist = 1'b0; i_refill_mode = 1'b0;
        i_invalidate_op = '0;
        mdl_direct = 1'b1; mdl_win0 = '0; mdl_win1 = '0;
        for (int i = 0; i < N_ENT; i++) begin
            mdl_tag[i] = '0; mdl_even[i] = '0; mdl_odd[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        ok_rsp = '0;
        ok_rsp.op_ok = 1'b1;

        // Direct mode after reset: address passes through
        w.r = blank_req(ACT_TRANSLATE); w.r.vaddr = 32'hffff_ffff;
        w.chk = 1; w.e = ok_rsp; w.e.paddr = 32'hffff_ffff; tbl.push_back(w);
        // Read of an empty entry: zeros
        w.r = blank_req(ACT_READ); w.r.index = 4'hf; w.e = ok_rsp; tbl.push_back(w);
        // Unknown invalidate selector
        w.r = blank_req(ACT_INVALIDATE); w.r.op = INV_BAD; w.e = ok_rsp; w.e.op_ok = 0;
        tbl.push_back(w);
        // Unknown action
        w.r = blank_req(ACT_TRANSLATE); w.r.action = 3'h7; w.r.vaddr = 32'h1234;
        w.e = ok_rsp; tbl.push_back(w);
        // Writes: extremes of fields, one entry not present, one odd size
        w.chk = 0;
        w.r = blank_req(ACT_WRITE); w.r.vaddr = 32'hffff_ffff; w.r.index = 4'hf;
        w.r.ps = 6'd12; w.r.asid = 10'h3ff; w.r.lo0 = 32'hffff_ffff; w.r.lo1 = 32'hffff_ffff;
        tbl.push_back(w);
        w.r = blank_req(ACT_WRITE); w.r.vaddr = 32'h0040_0000; w.r.index = 4'h0;
        w.r.ps = 6'd14; w.r.asid = 10'd1; w.r.lo0 = 32'h0000_1201; w.r.lo1 = 32'h0000_130f;
        tbl.push_back(w);
        w.r = blank_req(ACT_WRITE); w.r.vaddr = 32'h8000_0000; w.r.index = 4'h1;
        w.r.ps = 6'd30; w.r.lo0 = 32'h0fff_ff4f; w.r.lo1 = 32'h0000_004c;
        w.r.not_exist = 1; w.r.refill = 1; tbl.push_back(w);
        w.r = blank_req(ACT_WRITE); w.r.vaddr = 32'h2000_0000; w.r.index = 4'h2;
        w.r.ps = 6'h3f; w.r.lo0 = 32'h3; w.r.lo1 = 32'h3; tbl.push_back(w);
        w.r = blank_req(ACT_WRITE); w.r.vaddr = 32'h3000_0000; w.r.index = 4'h3;
        w.r.ps = 6'd12; w.r.lo0 = 32'h3; w.r.not_exist = 1; tbl.push_back(w);
        for (int i = 0; i < 4; i++) begin
            w.r = blank_req(ACT_READ); w.r.index = 4'(i); tbl.push_back(w);
        end
        w.r = blank_req(ACT_READ); w.r.index = 4'hf; tbl.push_back(w);
        w.r = blank_req(ACT_SEARCH); w.r.vaddr = 32'h0040_0000; w.r.asid = 1; tbl.push_back(w);
        w.r = blank_req(ACT_SEARCH); w.r.vaddr = 32'h0040_0000; w.r.asid = 2; tbl.push_back(w);
        w.r = blank_req(ACT_SEARCH); w.r.vaddr = 32'hffff_e000; tbl.push_back(w);
        foreach (tbl[k]) send_txn(tbl[k].r, tbl[k].chk, tbl[k].e);
        tbl.delete();
        drain_and_idle();

        // Paged mode: hits, refill misses, then every invalidate op
        write_cfg(CFG_DIRECT, 32'd0);
        for (int k = 0; k < 4; k++) begin
            r = blank_req(ACT_TRANSLATE); r.vaddr = 32'h0040_0000 | (k << 14) | 32'h123;
            r.asid = 1; r.kind = 2'(k); r.plv = 2'(k % 3);
            send_txn(r, 0, ok_rsp);
        end
        r = blank_req(ACT_TRANSLATE); r.vaddr = 32'h0040_4000; r.asid = 1; r.kind = KIND_STORE;
        r.plv = 2'd3; send_txn(r, 0, ok_rsp);
        r.vaddr = 32'h8123_4567; r.asid = 5; send_txn(r, 0, ok_rsp);
        r.vaddr = 32'h2000_0000; send_txn(r, 0, ok_rsp);
        r.vaddr = 32'h5555_5555; send_txn(r, 0, ok_rsp);
        for (int op = 0; op < 8; op++) begin
            r = blank_req(ACT_INVALIDATE); r.op = 3'(6 - op % 7); r.asid = 10'd1;
            r.vaddr = 32'h0040_0000; if (op == 7) r.op = INV_BAD;
            send_txn(r, 0, ok_rsp);
        end
        drain_and_idle();

        // Random phases across register settings, window extremes included
        win_cfg[0] = 32'h0000_0000;
        win_cfg[1] = 32'hffff_ffff;
        win_cfg[2] = 32'h8000_0009;
        win_cfg[3] = 32'ha200_0003;
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_DIRECT, ph == 5 ? 32'd1 : 32'($urandom_range(0, 5) == 0));
            write_cfg(CFG_WIN0, ph < 4 ? win_cfg[ph] : $urandom);
            write_cfg(CFG_WIN1, ph < 4 ? win_cfg[3 - ph] : 32'h0);
            if (ph == 4) quiet = 1;
            for (int n = 0; n < 80; n++) send_txn(rand_req(), 0, ok_rsp);
            drain_and_idle();
        end

        if (err_cnt == 0) begin
            $display("PASS tlb_translate_and_maintain");
        end else begin
            $display("FAIL tlb_translate_and_maintain");
        end
        $finish;
    end
endmodule

[filelist.f]
design/tlb_pkg.sv
design/tlb_store.sv
design/tlb_lookup.sv
design/tlb_translate_and_maintain.sv
design/tlb_checker.sv
dv/tlb_translate_and_maintain_tb.sv
